### src/wrtm_pkg.sv
`timescale 1ns / 1ps

package wrtm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int MI_W = 6;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [2:0] tgt;
		logic [4:0] word_class;
		logic [9:0] set_val;
		logic [9:0] subset;
		logic [4:0] superset;
		logic [6:0] form;
		logic [9:0] ofl3;
	} key_t;

	typedef struct packed {
		logic [9:0] scon12;
		logic [9:0] scon45;
		logic [6:0] wild_slot;
		logic [9:0] wild_value;
	} act_t;

	typedef struct packed {
		logic            matched;
		logic            status;
		logic [MI_W-1:0] match_index;
		logic [9:0]      new_scon12;
		logic [9:0]      new_scon45;
		logic            wild_valid;
		logic [6:0]      wild_field;
		logic [9:0]      wild_data;
	} res_t;

	// Item travelling down the row of cells
	typedef struct packed {
		logic valid;
		logic query;
		key_t key;
		res_t res;
	} flow_t;

endpackage

### src/wrtm_cell.sv
`timescale 1ns / 1ps

module wrtm_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [wrtm_pkg::IDX_W-1:0] cell_idx,
	input  logic [wrtm_pkg::CNT_W-1:0] entry_count,
	input  logic [2:0]              target_language,
	input  logic                    advance,
	input  logic                    wr_en,
	input  logic [wrtm_pkg::IDX_W-1:0] wr_idx,
	input  wrtm_pkg::key_t          wr_key,
	input  wrtm_pkg::act_t          wr_act,
	input  wrtm_pkg::flow_t         flow_in,
	output wrtm_pkg::flow_t         flow_out
);

	import wrtm_pkg::*;

	key_t key_q;
	act_t act_q;
	logic live;
	logic hit;
	logic [IDX_W+MI_W-1:0] idx_ext;
	flow_t nxt;
	logic flow_valid_q;
	flow_t flow_q;

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == cell_idx) begin
			key_q <= wr_key;
			act_q <= wr_act;
		end
	end

	assign live = CNT_W'(cell_idx) < entry_count;
	assign idx_ext = {{MI_W{1'b0}}, cell_idx};

	assign hit = (key_q.word_class == flow_in.key.word_class) &&
		(key_q.ofl3 == flow_in.key.ofl3) &&
		(key_q.subset == '0 || key_q.subset == flow_in.key.subset) &&
		(key_q.set_val == '0 || key_q.set_val == flow_in.key.set_val) &&
		(key_q.superset == '0 || key_q.superset == flow_in.key.superset) &&
		(key_q.form == '0 || key_q.form == flow_in.key.form) &&
		(key_q.tgt == '0 || key_q.tgt == target_language);

	always_comb begin
		nxt = flow_in;
		// first live entry that matches wins; later cells see matched set
		if (flow_in.valid && flow_in.query && !flow_in.res.matched && live && hit) begin
			nxt.res.matched     = 1'b1;
			nxt.res.match_index = idx_ext[MI_W-1:0];
			nxt.res.new_scon12  = act_q.scon12;
			nxt.res.new_scon45  = act_q.scon45;
			nxt.res.wild_valid  = act_q.wild_slot != '0;
			nxt.res.wild_field  = act_q.wild_slot;
			nxt.res.wild_data   = (act_q.wild_slot != '0) ? act_q.wild_value : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_valid_q <= 1'b0;
		end else if (advance) begin
			flow_valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flow_q <= nxt;
		end
	end

	always_comb begin
		flow_out = flow_q;
		flow_out.valid = flow_valid_q;
	end

endmodule

### src/wildcard_rule_table_match.sv
`timescale 1ns / 1ps

// Ordered rule table held in a row of TABLE_DEPTH cells, one entry per cell.
// Clear, append and query items all pass down the row, one cell per cycle
// while the row is not held by a stalled output; one item is in flight at a
// time, and a new item is taken as soon as the previous result sits in the
// output register. Clear and append change the table at acceptance. A query
// is compared with each cell's entry as it passes and picks up the first live
// match. target_language is to be written through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this.
module wildcard_rule_table_match (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] cmd,
	input  logic [2:0] entry_target,
	input  logic [4:0] key_word_class,
	input  logic [9:0] key_set,
	input  logic [9:0] key_subset,
	input  logic [4:0] key_superset,
	input  logic [6:0] key_form,
	input  logic [9:0] key_ofl3,
	input  logic [9:0] action_scon12,
	input  logic [9:0] action_scon45,
	input  logic [6:0] action_wild_slot,
	input  logic [9:0] action_wild_value,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       matched,
	output logic       status,
	output logic [5:0] match_index,
	output logic [9:0] new_scon12,
	output logic [9:0] new_scon45,
	output logic       wild_valid,
	output logic [6:0] wild_field,
	output logic [9:0] wild_data
);

	import wrtm_pkg::*;

	logic [2:0] target_language_q;
	logic [CNT_W-1:0] count_q;
	logic busy_q;
	logic out_valid_q;
	res_t res_q;

	logic accept;
	logic advance;
	logic full;
	logic wr_en;
	cmd_t cmd_c;
	key_t in_key;
	act_t in_act;
	flow_t chain [TABLE_DEPTH+1];
	flow_t tail;

	assign cmd_c = cmd_t'(cmd);
	assign accept = req_valid && req_ready;
	assign req_ready = !busy_q;
	assign full = count_q == CNT_W'(TABLE_DEPTH);
	assign wr_en = accept && cmd_c == CMD_APPEND && !full;

	assign in_key = '{tgt: entry_target, word_class: key_word_class, set_val: key_set,
		subset: key_subset, superset: key_superset, form: key_form, ofl3: key_ofl3};
	assign in_act = '{scon12: action_scon12, scon45: action_scon45,
		wild_slot: action_wild_slot, wild_value: action_wild_value};

	always_comb begin
		chain[0] = '0;
		chain[0].valid = accept;
		chain[0].key = in_key;
		unique case (cmd_c)
			CMD_QUERY:  chain[0].query = 1'b1;
			CMD_APPEND: chain[0].res.status = full;
			CMD_CLEAR:  chain[0].query = 1'b0;
			CMD_NONE:   chain[0].query = 1'b0;
			default:    chain[0].query = 1'b0;
		endcase
	end

	assign tail = chain[TABLE_DEPTH];
	// hold the row while a finished item waits on a stalled output
	assign advance = !(tail.valid && out_valid_q && !rsp_ready);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		wrtm_cell u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.cell_idx        (IDX_W'(i)),
			.entry_count     (count_q),
			.target_language (target_language_q),
			.advance         (advance),
			.wr_en           (wr_en),
			.wr_idx          (count_q[IDX_W-1:0]),
			.wr_key          (in_key),
			.wr_act          (in_act),
			.flow_in         (chain[i]),
			.flow_out        (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_language_q <= '0;
			count_q <= '0;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				target_language_q <= cfg_wr_data;
			end
			if (accept && cmd_c == CMD_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (advance && tail.valid) begin
				busy_q <= 1'b0;
			end
			if (advance && tail.valid) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tail.valid) begin
			res_q <= tail.res;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign matched     = res_q.matched;
	assign status      = res_q.status;
	assign match_index = res_q.match_index;
	assign new_scon12  = res_q.new_scon12;
	assign new_scon45  = res_q.new_scon45;
	assign wild_valid  = res_q.wild_valid;
	assign wild_field  = res_q.wild_field;
	assign wild_data   = res_q.wild_data;

endmodule
